@@ hw/rtl/abps_pkg.sv @@
package abps_pkg;

    // Fixed field widths of the pixel transaction.
    localparam int REG_W       = 9;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int ALPHA_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int SUM_W       = 16;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_INDEX_W = 1;

    // Width of y*width + x before it is cut to the memory address.
    localparam int ADDR_SUM_W  = 2 * REG_W + 1;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;
    localparam logic [ALPHA_W-1:0] ZERO_ALPHA = 8'h00;

    // Opcodes carried on s_tuser.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Command kinds decided by the front end.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;
    localparam logic [1:0] KIND_BLEND = 2'd3;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic               in_bounds;
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
    } cmd_t;

endpackage

@@ hw/rtl/abps_front.sv @@
module abps_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int AW         = 16
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [abps_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic [abps_pkg::REG_W-1:0]        screen_width,
    input  logic [abps_pkg::REG_W-1:0]        screen_height,
    input  logic                              clear_busy,
    output logic                              push_valid,
    input  logic                              push_ready,
    output abps_pkg::cmd_t                    push_cmd,
    output logic [AW-1:0]                     push_addr
);

    localparam int REG_W   = abps_pkg::REG_W;
    localparam int COORD_W = abps_pkg::COORD_W;
    localparam int SUM_W   = abps_pkg::ADDR_SUM_W;
    localparam int PW      = (AW > SUM_W) ? AW : SUM_W;

    logic [COORD_W-1:0]               pos_x;
    logic [COORD_W-1:0]               pos_y;
    logic [abps_pkg::COLOR_W-1:0]     fg_color;
    logic [abps_pkg::ALPHA_W-1:0]     blend_alpha;
    logic [REG_W-1:0]                 eff_width;
    logic [REG_W-1:0]                 eff_height;
    logic                             on_screen;
    logic [2*REG_W-1:0]               row_base;
    logic [PW-1:0]                    addr_wide;

    // Unpack the transaction fields.
    assign pos_x       = s_tdata[15:0];
    assign pos_y       = s_tdata[31:16];
    assign fg_color    = s_tdata[55:32];
    assign blend_alpha = s_tdata[63:56];

    // Register values above the memory geometry are clipped to it.
    always_comb begin
        if (int'(screen_width) > MAX_WIDTH) begin
            eff_width = REG_W'(MAX_WIDTH);
        end else begin
            eff_width = screen_width;
        end
        if (int'(screen_height) > MAX_HEIGHT) begin
            eff_height = REG_W'(MAX_HEIGHT);
        end else begin
            eff_height = screen_height;
        end
    end

    // Bounds check on the signed coordinates.
    assign on_screen = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
                       (COORD_W'(eff_width) > pos_x) && (COORD_W'(eff_height) > pos_y);

    // Linear address; inside the screen y and x both fit in the register width.
    assign row_base  = (2*REG_W)'(pos_y[REG_W-1:0]) * (2*REG_W)'(eff_width);
    assign addr_wide = PW'(row_base) + PW'(pos_x[REG_W-1:0]);
    assign push_addr = addr_wide[AW-1:0];

    // Classify the transaction for the back end.
    always_comb begin
        push_cmd.in_bounds = on_screen;
        push_cmd.color     = fg_color;
        push_cmd.alpha     = blend_alpha;
        if (!on_screen) begin
            push_cmd.kind = abps_pkg::KIND_NONE;
        end else if (s_tuser == abps_pkg::OP_READ) begin
            push_cmd.kind = abps_pkg::KIND_READ;
        end else if (blend_alpha == abps_pkg::FULL_ALPHA) begin
            push_cmd.kind = abps_pkg::KIND_STORE;
        end else if (blend_alpha == abps_pkg::ZERO_ALPHA) begin
            push_cmd.kind = abps_pkg::KIND_NONE;
        end else begin
            push_cmd.kind = abps_pkg::KIND_BLEND;
        end
    end

    // No transaction is taken while the pixel memory is being cleared.
    assign push_valid = s_tvalid && !clear_busy;
    assign s_tready   = push_ready && !clear_busy;

endmodule

@@ hw/rtl/abps_queue.sv @@
module abps_queue #(
    parameter int AW = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  abps_pkg::cmd_t      push_cmd,
    input  logic [AW-1:0]       push_addr,
    output logic                pop_valid,
    input  logic                pop_ready,
    output abps_pkg::cmd_t      pop_cmd,
    output logic [AW-1:0]       pop_addr
);

    localparam int PTR_W = abps_pkg::QUEUE_PTR_W;
    localparam int CNT_W = abps_pkg::QUEUE_CNT_W;

    abps_pkg::cmd_t     slot_cmd_reg  [abps_pkg::QUEUE_DEPTH];
    logic [AW-1:0]      slot_addr_reg [abps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(abps_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = slot_cmd_reg[rd_ptr_reg];
    assign pop_addr   = slot_addr_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage carries payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_cmd_reg[wr_ptr_reg]  <= push_cmd;
            slot_addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

@@ hw/rtl/abps_back.sv @@
module abps_back #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  abps_pkg::cmd_t                    pop_cmd,
    input  logic [AW-1:0]                     pop_addr,
    output logic                              clear_busy,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [abps_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam int COLOR_W = abps_pkg::COLOR_W;
    localparam int CHAN_W  = abps_pkg::CHAN_W;
    localparam int SUM_W   = abps_pkg::SUM_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [COLOR_W-1:0]  pixel_mem [DEPTH];

    logic [1:0]          state_reg, state_next;
    logic                clear_busy_reg, clear_busy_next;
    logic [AW-1:0]       clear_cnt_reg, clear_cnt_next;
    abps_pkg::cmd_t      cur_cmd_reg, cur_cmd_next;
    logic [AW-1:0]       cur_addr_reg, cur_addr_next;
    logic [COLOR_W-1:0]  rd_data_reg;
    logic [SUM_W-1:0]    sum_reg  [abps_pkg::NUM_CHAN];
    logic [SUM_W-1:0]    sum_next [abps_pkg::NUM_CHAN];
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  out_data_reg, out_data_next;
    logic                out_bounds_reg, out_bounds_next;

    logic                out_free;
    logic                take;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [COLOR_W-1:0]  mem_wdata;
    logic                rd_en;
    logic [COLOR_W-1:0]  blend_pix;

    assign out_free   = !out_valid_reg || m_tready;
    assign pop_ready  = !clear_busy_reg && (state_reg == ST_IDLE) && out_free;
    assign take       = pop_valid && pop_ready;
    assign clear_busy = clear_busy_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser    = out_bounds_reg;

    // Weighted channel sums from the background just read; one 8x8 product pair each.
    always_comb begin
        logic [CHAN_W-1:0] fg_c;
        logic [CHAN_W-1:0] bg_c;
        logic [CHAN_W-1:0] inv_alpha;
        inv_alpha = abps_pkg::FULL_ALPHA - cur_cmd_reg.alpha;
        for (int c = 0; c < abps_pkg::NUM_CHAN; c++) begin
            fg_c = cur_cmd_reg.color[c*CHAN_W +: CHAN_W];
            bg_c = rd_data_reg[c*CHAN_W +: CHAN_W];
            sum_next[c] = ({8'd0, fg_c} * {8'd0, cur_cmd_reg.alpha}) +
                          ({8'd0, bg_c} * {8'd0, inv_alpha});
        end
    end

    // Division by 255 as (n + 1 + n/256) / 256, exact for sums below 65280.
    always_comb begin
        logic [SUM_W:0] t;
        for (int c = 0; c < abps_pkg::NUM_CHAN; c++) begin
            t = (SUM_W+1)'(sum_reg[c]) + (SUM_W+1)'(1) + (SUM_W+1)'(sum_reg[c][SUM_W-1:CHAN_W]);
            blend_pix[c*CHAN_W +: CHAN_W] = t[SUM_W-1:CHAN_W];
        end
    end

    // Sequencer: clearing pass, then one command at a time.
    always_comb begin
        state_next      = state_reg;
        clear_busy_next = clear_busy_reg;
        clear_cnt_next  = clear_cnt_reg;
        cur_cmd_next    = take ? pop_cmd : cur_cmd_reg;
        cur_addr_next   = take ? pop_addr : cur_addr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_bounds_next = out_bounds_reg;
        mem_we          = 1'b0;
        mem_waddr       = clear_cnt_reg;
        mem_wdata       = '0;
        rd_en           = 1'b0;

        if (clear_busy_reg) begin
            mem_we          = 1'b1;
            clear_cnt_next  = clear_cnt_reg + AW'(1);
            clear_busy_next = (clear_cnt_reg != AW'(DEPTH - 1));
        end

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (pop_cmd.kind)
                        abps_pkg::KIND_READ,
                        abps_pkg::KIND_BLEND: begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        abps_pkg::KIND_STORE: begin
                            mem_we          = 1'b1;
                            mem_waddr       = pop_addr;
                            mem_wdata       = pop_cmd.color;
                            out_valid_next  = 1'b1;
                            out_data_next   = '0;
                            out_bounds_next = pop_cmd.in_bounds;
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_data_next   = '0;
                            out_bounds_next = pop_cmd.in_bounds;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (cur_cmd_reg.kind == abps_pkg::KIND_READ) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_data_reg;
                    out_bounds_next = cur_cmd_reg.in_bounds;
                    state_next      = ST_IDLE;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_we          = 1'b1;
                mem_waddr       = cur_addr_reg;
                mem_wdata       = blend_pix;
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_bounds_next = cur_cmd_reg.in_bounds;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clear_busy_reg <= clear_busy_next;
            clear_cnt_reg  <= clear_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_cmd_reg    <= cur_cmd_next;
        cur_addr_reg   <= cur_addr_next;
        out_data_reg   <= out_data_next;
        out_bounds_reg <= out_bounds_next;
        for (int c = 0; c < abps_pkg::NUM_CHAN; c++) begin
            sum_reg[c] <= sum_next[c];
        end
    end

    // Pixel memory: one write port, one read port with registered data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= pixel_mem[pop_addr];
        end
    end

endmodule

@@ hw/rtl/alpha_blend_pixel_store_unit.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  tdata: pos_x, pos_y, fg_color, blend_alpha
//                                           tuser: opcode
// m_        out        m_tvalid / m_tready  tdata: read_data; tuser: in_bounds
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// In the back end a transaction that leaves memory untouched or stores an opaque colour is
// done in the idle state, a read passes the read state, and a blended write runs the read,
// weight and write-back sequence on the pixel memory, whose read data is registered; a new
// command is taken only in the idle state.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT pixels (65536 by
// default), during which s_tready is low.
// A two-entry command queue separates the front and back ends, so input transactions are
// still taken while a result waits on a stalled m_ channel.
module alpha_blend_pixel_store_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [abps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [abps_pkg::REG_W-1:0]            cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pos_x [15:0], pos_y [31:16], fg_color [55:32], blend_alpha [63:56]
    input  logic [abps_pkg::S_TDATA_W-1:0]        s_tdata,
    // opcode [0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // read_data [23:0]
    output logic [abps_pkg::M_TDATA_W-1:0]        m_tdata,
    // in_bounds [0]
    output logic                                  m_tuser
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [abps_pkg::REG_W-1:0] width_reg, width_next;
    logic [abps_pkg::REG_W-1:0] height_reg, height_next;

    logic                push_valid;
    logic                push_ready;
    abps_pkg::cmd_t      push_cmd;
    logic [AW-1:0]       push_addr;
    logic                pop_valid;
    logic                pop_ready;
    abps_pkg::cmd_t      pop_cmd;
    logic [AW-1:0]       pop_addr;
    logic                clear_busy;

    // Screen geometry registers; unknown indexes are ignored.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_index)
                abps_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_wdata;
                abps_pkg::REG_SCREEN_HEIGHT: height_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    abps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .clear_busy    (clear_busy),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd),
        .push_addr     (push_addr)
    );

    abps_queue #(
        .AW (AW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .pop_addr   (pop_addr)
    );

    abps_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .pop_addr   (pop_addr),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
